### src/krp_pkg.sv
// ---------------------------------------------------------------------------
// krp_pkg: shared types and constants of the keyframe ramp player
// Field widths, request and register codes, reset values and the
// structs that connect the sequencer to the serial divider.
// ---------------------------------------------------------------------------
`default_nettype none

package krp_pkg;

   // payload widths
   localparam int KEY_W       = 9;    // keyframe angle, whole degrees
   localparam int FRAC_W      = 16;   // fraction bits of positions
   localparam int POS_W       = 25;   // saturated position
   localparam int INC_W       = 26;   // signed increment
   localparam int SUM_W       = 27;   // position plus increment before saturation
   localparam int STEP_W      = 12;
   localparam int LAST_W      = 3;
   localparam int SEG_W       = 3;
   localparam int FSEL_W      = 3;
   localparam int CSEL_W      = 3;
   localparam int REQ_W       = 2;
   localparam int NUM_POS_OUT = 5;

   // divider: |diff| has at most KEY_W bits, shifted by FRAC_W
   localparam int DVD_W       = KEY_W + FRAC_W;

   // configuration port
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   // request codes
   localparam logic [REQ_W-1:0] REQ_TICK   = 2'd0;
   localparam logic [REQ_W-1:0] REQ_TOGGLE = 2'd1;
   localparam logic [REQ_W-1:0] REQ_WRITE  = 2'd2;

   // register indexes (word address bit)
   localparam logic REG_STEP_COUNT = 1'b0;
   localparam logic REG_LAST_FRAME = 1'b1;

   // register reset values
   localparam logic [STEP_W-1:0] STEP_COUNT_RST = 12'd3000;
   localparam logic [LAST_W-1:0] LAST_FRAME_RST = 3'd7;

   // saturation bounds
   localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

   typedef struct packed {
      logic              start;
      logic [DVD_W-1:0]  dividend;
      logic [STEP_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DVD_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

### src/krp_ram.sv
// ---------------------------------------------------------------------------
// krp_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module krp_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

### src/krp_div.sv
// ---------------------------------------------------------------------------
// krp_div: serial restoring divider
// Unsigned dividend by 12-bit divisor, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module krp_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire krp_pkg::div_req_type div_req,
   output krp_pkg::div_rsp_type      div_rsp
);

   localparam int CNT_W = $clog2(krp_pkg::DVD_W);
   localparam int REM_W = krp_pkg::STEP_W + 1;

   logic [krp_pkg::DVD_W-1:0]  dvd_ff, dvd_in;
   logic [krp_pkg::STEP_W-1:0] dvs_ff, dvs_in;
   logic [krp_pkg::STEP_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [REM_W-1:0]           trial;
   logic [REM_W-1:0]           diff;
   logic                       qbit;

   assign trial = {rem_ff, dvd_ff[krp_pkg::DVD_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign qbit  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         dvd_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift the next dividend bit in, keep the quotient bit
         rem_in = qbit ? diff[krp_pkg::STEP_W-1:0] : trial[krp_pkg::STEP_W-1:0];
         dvd_in = {dvd_ff[krp_pkg::DVD_W-2:0], qbit};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(krp_pkg::DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = dvd_ff;

endmodule

`default_nettype wire

### src/keyframe_ramp_player.sv
// ---------------------------------------------------------------------------
// keyframe_ramp_player: multi-channel keyframe ramp player
// Plays linear ramps between keyframe angles held in a small table,
// with per-segment increments from one shared serial divider.
// ---------------------------------------------------------------------------
//
//  channel   direction  handshake          payload
//  req_      in         req_valid/ready    req_type, req_frame_sel,
//                                          req_channel_sel, req_key_value
//  rsp_      out        rsp_valid/ready    rsp_pos_ch0..4, rsp_playing,
//                                          rsp_segment, rsp_done_res
//  csr_      in/out     APB, pready = 1    step_count @0x0, last_frame @0x4
//
//  Steps: write, stop, idle or final tick go straight to the result; a ramp tick adds
//  each channel in turn; start or advance per channel: two reads, divider start, divider wait.
//  Reset is synchronous; per-entry valid bits clear the table, ready right after.
//  A stalled result holds the output register; the next item is still taken
//  and its result waits in the sequencer until the register frees up.
// ---------------------------------------------------------------------------
`default_nettype none

module keyframe_ramp_player #(
   parameter int FRAMES   = 8,
   parameter int CHANNELS = 5
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request channel
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic        [krp_pkg::REQ_W-1:0]     req_type,
   input  wire logic        [krp_pkg::FSEL_W-1:0]    req_frame_sel,
   input  wire logic        [krp_pkg::CSEL_W-1:0]    req_channel_sel,
   input  wire logic signed [krp_pkg::KEY_W-1:0]     req_key_value,
   // result channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic signed      [krp_pkg::POS_W-1:0]     rsp_pos_ch0,
   output logic signed      [krp_pkg::POS_W-1:0]     rsp_pos_ch1,
   output logic signed      [krp_pkg::POS_W-1:0]     rsp_pos_ch2,
   output logic signed      [krp_pkg::POS_W-1:0]     rsp_pos_ch3,
   output logic signed      [krp_pkg::POS_W-1:0]     rsp_pos_ch4,
   output logic                                      rsp_playing,
   output logic             [krp_pkg::SEG_W-1:0]     rsp_segment,
   output logic                                      rsp_done_res,
   // configuration port
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic        [krp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic        [krp_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic             [krp_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                      csr_pready
);

   // Only frames 0..7 are addressable, so the table holds at most eight.
   localparam int TAB_FRAMES = (FRAMES < 8) ? FRAMES : 8;
   localparam int FRW        = $clog2(TAB_FRAMES);
   localparam int CHW        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int AW         = FRW + CHW;
   localparam int DEPTH      = 1 << AW;

   localparam int POS_W = krp_pkg::POS_W;
   localparam int INC_W = krp_pkg::INC_W;
   localparam int SUM_W = krp_pkg::SUM_W;
   localparam int KEY_W = krp_pkg::KEY_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_RD_CUR,
      ST_RD_NXT,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_FINISH
   } state_type;

   // sequencer and play state
   state_type                        state_ff, state_in;
   logic [CHW-1:0]                   ch_ff, ch_in;
   logic [krp_pkg::SEG_W-1:0]        seg_ff, seg_in;
   logic [krp_pkg::STEP_W-1:0]       tick_ff, tick_in;
   logic                             play_ff, play_in;
   logic                             done_ff, done_in;
   logic                             load_ff, load_in;
   logic signed [POS_W-1:0]          pos_ff [CHANNELS];
   logic signed [POS_W-1:0]          pos_in [CHANNELS];
   logic signed [INC_W-1:0]          inc_ff [CHANNELS];
   logic signed [INC_W-1:0]          inc_in [CHANNELS];
   logic [DEPTH-1:0]                 valid_ff, valid_in;
   logic                             rd_ok_ff, rd_ok_in;
   logic signed [KEY_W-1:0]          cur_ff, cur_in;
   logic                             neg_ff, neg_in;

   // configuration registers
   logic [krp_pkg::STEP_W-1:0]       step_ff, step_in;
   logic [krp_pkg::LAST_W-1:0]       last_ff, last_in;

   // output register
   logic                             rsp_valid_ff, rsp_valid_in;
   logic signed [POS_W-1:0]          rsp_pos_ff [krp_pkg::NUM_POS_OUT];
   logic signed [POS_W-1:0]          rsp_pos_in [krp_pkg::NUM_POS_OUT];
   logic                             rsp_play_ff, rsp_play_in;
   logic [krp_pkg::SEG_W-1:0]        rsp_seg_ff, rsp_seg_in;
   logic                             rsp_done_ff, rsp_done_in;

   // datapath
   logic signed [POS_W-1:0]          pos_view [krp_pkg::NUM_POS_OUT];
   logic [krp_pkg::SEG_W:0]          rd_frame;
   logic [krp_pkg::SEG_W:0]          seg_next;
   logic [AW-1:0]                    rd_addr;
   logic [AW-1:0]                    wr_addr;
   logic                             ram_we;
   logic [KEY_W-1:0]                 ram_rdata;
   logic signed [KEY_W-1:0]          key_rd;
   logic signed [KEY_W:0]            key_diff;
   logic [KEY_W-1:0]                 key_mag;
   logic signed [SUM_W-1:0]          add_sum;
   logic signed [POS_W-1:0]          add_sat;
   logic signed [INC_W-1:0]          quo_ext;
   logic                             ch_last;
   logic                             wr_hit;
   logic                             csr_wr;
   krp_pkg::div_req_type             div_req;
   krp_pkg::div_rsp_type             div_rsp;

   // ------------------------------------------------------------------
   // keyframe table and shared divider
   // ------------------------------------------------------------------
   krp_ram #(
      .WIDTH (KEY_W),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_addr),
      .wr_data (req_key_value),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   krp_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // ------------------------------------------------------------------
   // table addressing: current frame, then the next one
   // ------------------------------------------------------------------
   assign seg_next = {1'b0, seg_ff} + 1'b1;
   assign rd_frame = (state_ff == ST_RD_NXT) ? seg_next : {1'b0, seg_ff};
   assign rd_addr  = {rd_frame[FRW-1:0], ch_ff};
   // an entry never written, or a frame beyond the table, reads as zero
   assign rd_ok_in = (32'(rd_frame) < FRAMES) && valid_ff[rd_addr];
   assign key_rd   = rd_ok_ff ? signed'(ram_rdata) : '0;

   assign wr_addr  = {req_frame_sel[FRW-1:0], req_channel_sel[CHW-1:0]};
   assign wr_hit   = (32'(req_frame_sel) < FRAMES) && (32'(req_channel_sel) < CHANNELS);

   // difference to the next frame, as sign and magnitude
   assign key_diff = {key_rd[KEY_W-1], key_rd} - {cur_ff[KEY_W-1], cur_ff};
   assign key_mag  = key_diff[KEY_W] ? KEY_W'(-key_diff) : key_diff[KEY_W-1:0];
   assign quo_ext  = signed'({1'b0, div_rsp.quotient});

   // shared saturating adder for ticks
   assign add_sum = {{(SUM_W-POS_W){pos_ff[ch_ff][POS_W-1]}}, pos_ff[ch_ff]}
                    + {{(SUM_W-INC_W){inc_ff[ch_ff][INC_W-1]}}, inc_ff[ch_ff]};
   always_comb begin
      if (add_sum[SUM_W-1:POS_W-1] == '0 || add_sum[SUM_W-1:POS_W-1] == '1) begin
         add_sat = add_sum[POS_W-1:0];
      end else begin
         add_sat = add_sum[SUM_W-1] ? krp_pkg::POS_MIN : krp_pkg::POS_MAX;
      end
   end

   assign ch_last = (ch_ff == CHW'(CHANNELS - 1));
   assign csr_wr  = csr_psel && csr_penable && csr_pwrite;

   // result view: channels beyond CHANNELS read as zero
   for (genvar j = 0; j < krp_pkg::NUM_POS_OUT; j++) begin : g_view
      if (j < CHANNELS) begin : g_live
         assign pos_view[j] = pos_ff[j];
      end else begin : g_zero
         assign pos_view[j] = '0;
      end
   end

   // ------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      seg_in       = seg_ff;
      tick_in      = tick_ff;
      play_in      = play_ff;
      done_in      = done_ff;
      load_in      = load_ff;
      pos_in       = pos_ff;
      inc_in       = inc_ff;
      valid_in     = valid_ff;
      cur_in       = cur_ff;
      neg_in       = neg_ff;
      step_in      = step_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pos_in   = rsp_pos_ff;
      rsp_play_in  = rsp_play_ff;
      rsp_seg_in   = rsp_seg_ff;
      rsp_done_in  = rsp_done_ff;
      ram_we       = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = {key_mag, {krp_pkg::FRAC_W{1'b0}}};
      // a zero step count divides as one
      div_req.divisor  = (step_ff == '0) ? krp_pkg::STEP_W'(1) : step_ff;

      // the user must make register writes only while the block is idle; the block does not enforce it
      if (csr_wr) begin
         case (csr_paddr[2])
            krp_pkg::REG_STEP_COUNT: step_in = csr_pwdata[krp_pkg::STEP_W-1:0];
            krp_pkg::REG_LAST_FRAME: last_in = csr_pwdata[krp_pkg::LAST_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               done_in  = 1'b0;
               ch_in    = '0;
               state_in = ST_FINISH;
               case (req_type)
                  krp_pkg::REQ_TICK: begin
                     if (play_ff) begin
                        if (tick_ff >= step_ff) begin
                           // advance tick: no increments added
                           if (seg_next >= {1'b0, last_ff}) begin
                              seg_in  = '0;
                              play_in = 1'b0;
                              done_in = 1'b1;
                           end else begin
                              tick_in  = '0;
                              seg_in   = seg_next[krp_pkg::SEG_W-1:0];
                              load_in  = 1'b0;
                              state_in = ST_RD_CUR;
                           end
                        end else begin
                           state_in = ST_ADD;
                        end
                     end
                  end
                  krp_pkg::REQ_TOGGLE: begin
                     if (!play_ff && last_ff != '0) begin
                        // start: load frame 0 and ramp segment 0
                        seg_in   = '0;
                        tick_in  = '0;
                        play_in  = 1'b1;
                        load_in  = 1'b1;
                        state_in = ST_RD_CUR;
                     end else begin
                        play_in = 1'b0;
                     end
                  end
                  krp_pkg::REQ_WRITE: begin
                     if (wr_hit) begin
                        ram_we            = 1'b1;
                        valid_in[wr_addr] = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end

         ST_ADD: begin
            pos_in[ch_ff] = add_sat;
            if (ch_last) begin
               tick_in  = tick_ff + 1'b1;
               state_in = ST_FINISH;
            end else begin
               ch_in = ch_ff + 1'b1;
            end
         end

         ST_RD_CUR: begin
            state_in = ST_RD_NXT;
         end

         ST_RD_NXT: begin
            // current frame's key is on the read port now
            cur_in = key_rd;
            if (load_ff) begin
               pos_in[ch_ff] = {key_rd, {krp_pkg::FRAC_W{1'b0}}};
            end
            state_in = ST_DIV_GO;
         end

         ST_DIV_GO: begin
            neg_in        = key_diff[KEY_W];
            div_req.start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end

         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               inc_in[ch_ff] = neg_ff ? -quo_ext : quo_ext;
               if (ch_last) begin
                  state_in = ST_FINISH;
               end else begin
                  ch_in    = ch_ff + 1'b1;
                  state_in = ST_RD_CUR;
               end
            end
         end

         ST_FINISH: begin
            // hold the result until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = pos_view;
               rsp_play_in  = play_ff;
               rsp_seg_in   = seg_ff;
               rsp_done_in  = done_ff;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ch_ff        <= '0;
         seg_ff       <= '0;
         tick_ff      <= '0;
         play_ff      <= 1'b0;
         done_ff      <= 1'b0;
         load_ff      <= 1'b0;
         valid_ff     <= '0;
         rd_ok_ff     <= 1'b0;
         step_ff      <= krp_pkg::STEP_COUNT_RST;
         last_ff      <= krp_pkg::LAST_FRAME_RST;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) begin
            pos_ff[c] <= '0;
            inc_ff[c] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         seg_ff       <= seg_in;
         tick_ff      <= tick_in;
         play_ff      <= play_in;
         done_ff      <= done_in;
         load_ff      <= load_in;
         valid_ff     <= valid_in;
         rd_ok_ff     <= rd_ok_in;
         step_ff      <= step_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         inc_ff       <= inc_in;
      end
      cur_ff      <= cur_in;
      neg_ff      <= neg_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_play_ff <= rsp_play_in;
      rsp_seg_ff  <= rsp_seg_in;
      rsp_done_ff <= rsp_done_in;
   end

   // ------------------------------------------------------------------
   // ports
   // ------------------------------------------------------------------
   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_pos_ch0  = rsp_pos_ff[0];
   assign rsp_pos_ch1  = rsp_pos_ff[1];
   assign rsp_pos_ch2  = rsp_pos_ff[2];
   assign rsp_pos_ch3  = rsp_pos_ff[3];
   assign rsp_pos_ch4  = rsp_pos_ff[4];
   assign rsp_playing  = rsp_play_ff;
   assign rsp_segment  = rsp_seg_ff;
   assign rsp_done_res = rsp_done_ff;

   assign csr_pready = 1'b1;
   always_comb begin
      case (csr_paddr[2])
         krp_pkg::REG_STEP_COUNT:
            csr_prdata = krp_pkg::CSR_DATA_W'(step_ff);
         krp_pkg::REG_LAST_FRAME:
            csr_prdata = krp_pkg::CSR_DATA_W'(last_ff);
         default: csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

### src/krp_checker.sv
// ---------------------------------------------------------------------------
// krp_checker: port-level checks of the keyframe ramp player
// Watches the request and result channels, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module krp_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_ready,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic signed [krp_pkg::POS_W-1:0]  rsp_pos_ch0,
   input wire logic                              rsp_playing,
   input wire logic        [krp_pkg::SEG_W-1:0]  rsp_segment,
   input wire logic                              rsp_done_res
);

   // the item that ends play leaves the player stopped at segment zero
   a_done_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_playing && rsp_segment == '0)
      else $error("done item shows play still running");

   // an accepted item keeps the sequencer busy in the following cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken twice in a row");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pos_ch0)
                                  && $stable(rsp_done_res))
      else $error("stalled result dropped or changed");

   // reset leaves no result pending
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind keyframe_ramp_player krp_checker u_krp_checker (.*);

`default_nettype wire

### test/keyframe_ramp_player_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// keyframe_ramp_player_tb: self-checking bench for the keyframe ramp player
// Tracks the keyframe table, positions and increments in a local tracker,
// predicts one result per accepted item and compares every result field
// by field. Runs directed corner items, then randomized play sequences
// across several register settings and handshake idling patterns.
// ---------------------------------------------------------------------------
module keyframe_ramp_player_tb;

   localparam int FRAMES      = 8;
   localparam int CHANNELS    = 5;
   localparam int PHASES      = 12;
   localparam int PHASE_ITEMS = 125;
   localparam int STALL_LIMIT = 4000;   // cycles with no handshake at all
   localparam int TAIL_CYCLES = 200;    // longer than a segment start

   localparam int REQ_W       = krp_pkg::REQ_W;
   localparam int FSEL_W      = krp_pkg::FSEL_W;
   localparam int CSEL_W      = krp_pkg::CSEL_W;
   localparam int KEY_W       = krp_pkg::KEY_W;
   localparam int POS_W       = krp_pkg::POS_W;
   localparam int SEG_W       = krp_pkg::SEG_W;
   localparam int FRAC_W      = krp_pkg::FRAC_W;
   localparam int NUM_POS_OUT = krp_pkg::NUM_POS_OUT;

   // request code the block must treat as a no-op
   localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

   // idling patterns, one per phase in rotation
   typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   // one result item as seen on the rsp_ port
   typedef struct packed {
      logic [NUM_POS_OUT-1:0][POS_W-1:0] pos;
      logic                              playing;
      logic [SEG_W-1:0]                  segment;
      logic                              done;
   } ramp_frame_type;

   // -------------------------------------------------------------------------
   // Ramp tracker: mirrors the player state and queues the frames it expects
   // -------------------------------------------------------------------------
   class ramp_tracker_type;
      int             key_tab [FRAMES][CHANNELS];
      longint         pos_acc [CHANNELS];
      longint         inc_acc [CHANNELS];
      int unsigned    tick_cnt;
      int unsigned    seg_idx;
      bit             running;
      int unsigned    step_cfg;
      int unsigned    last_cfg;
      ramp_frame_type frames_due[$];
      int             faults;

      function new();
         foreach (key_tab[f, c]) key_tab[f][c] = 0;
         foreach (pos_acc[c]) begin
            pos_acc[c] = 0;
            inc_acc[c] = 0;
         end
         tick_cnt = 0;
         seg_idx  = 0;
         running  = 0;
         step_cfg = krp_pkg::STEP_COUNT_RST;
         last_cfg = krp_pkg::LAST_FRAME_RST;
         faults   = 0;
      endfunction

      function void flag(string msg);
         faults++;
         if (faults <= 10)
            $display("%0t: mismatch: %s", $time, msg);
      endfunction

      function int key_at(int unsigned f, int unsigned c);
         if (f >= FRAMES || c >= CHANNELS)
            return 0;
         return key_tab[f][c];
      endfunction

      function longint clamp(longint v);
         if (v > longint'(krp_pkg::POS_MAX))
            return longint'(krp_pkg::POS_MAX);
         if (v < longint'(krp_pkg::POS_MIN))
            return longint'(krp_pkg::POS_MIN);
         return v;
      endfunction

      // per-channel slope of one segment, truncated toward zero
      function void load_increments(int unsigned seg);
         longint divisor;
         int     diff;
         longint mag;
         longint quo;
         divisor = (step_cfg != 0) ? longint'(step_cfg) : 64'sd1;
         for (int c = 0; c < CHANNELS; c++) begin
            diff       = key_at(seg + 1, c) - key_at(seg, c);
            mag        = (diff < 0) ? -longint'(diff) : longint'(diff);
            quo        = (mag << FRAC_W) / divisor;
            inc_acc[c] = (diff < 0) ? -quo : quo;
         end
      endfunction

      function void set_register(logic idx, int unsigned value);
         if (idx == krp_pkg::REG_STEP_COUNT)
            step_cfg = value & 32'hFFF;
         else
            last_cfg = value & 32'h7;
      endfunction

      function void take_item(logic [REQ_W-1:0] kind, logic [FSEL_W-1:0] fsel,
                              logic [CSEL_W-1:0] csel, logic signed [KEY_W-1:0] kv);
         ramp_frame_type want;
         bit             done;
         done = 0;
         case (kind)
            krp_pkg::REQ_TICK: begin
               if (running) begin
                  if (tick_cnt >= step_cfg) begin
                     // segment boundary: move on, no increment added
                     seg_idx++;
                     if (seg_idx >= last_cfg) begin
                        seg_idx = 0;
                        running = 0;
                        done    = 1;
                     end else begin
                        tick_cnt = 0;
                        load_increments(seg_idx);
                     end
                  end else begin
                     for (int c = 0; c < CHANNELS; c++)
                        pos_acc[c] = clamp(pos_acc[c] + inc_acc[c]);
                     tick_cnt = (tick_cnt + 1) & 32'hFFF;
                  end
               end
            end
            krp_pkg::REQ_TOGGLE: begin
               if (!running && last_cfg >= 1) begin
                  for (int c = 0; c < CHANNELS; c++)
                     pos_acc[c] = clamp(longint'(key_at(0, c)) * (64'sd1 << FRAC_W));
                  seg_idx = 0;
                  load_increments(0);
                  running  = 1;
                  tick_cnt = 0;
               end else begin
                  running = 0;
               end
            end
            krp_pkg::REQ_WRITE: begin
               if (fsel < FRAMES && csel < CHANNELS)
                  key_tab[fsel][csel] = int'(kv);
            end
            default: ;
         endcase
         for (int c = 0; c < NUM_POS_OUT; c++)
            want.pos[c] = (c < CHANNELS) ? POS_W'(pos_acc[c]) : '0;
         want.playing = running;
         want.segment = SEG_W'(seg_idx);
         want.done    = done;
         frames_due.push_back(want);
      endfunction

      function void check_frame(ramp_frame_type got);
         ramp_frame_type want;
         if (frames_due.size() == 0) begin
            flag("result arrived with no item outstanding");
            return;
         end
         want = frames_due.pop_front();
         for (int c = 0; c < NUM_POS_OUT; c++)
            if (got.pos[c] !== want.pos[c])
               flag($sformatf("ch%0d position expected %0d got %0d", c,
                              $signed(want.pos[c]), $signed(got.pos[c])));
         if (got.playing !== want.playing)
            flag($sformatf("playing expected %0b got %0b", want.playing, got.playing));
         if (got.segment !== want.segment)
            flag($sformatf("segment expected %0d got %0d", want.segment, got.segment));
         if (got.done !== want.done)
            flag($sformatf("done expected %0b got %0b", want.done, got.done));
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals
   // -------------------------------------------------------------------------
   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;

   logic                                  req_valid       = 1'b0;
   logic                                  req_ready;
   logic        [REQ_W-1:0]               req_type        = krp_pkg::REQ_TICK;
   logic        [FSEL_W-1:0]              req_frame_sel   = '0;
   logic        [CSEL_W-1:0]              req_channel_sel = '0;
   logic signed [KEY_W-1:0]               req_key_value   = '0;

   logic                                  rsp_valid;
   logic                                  rsp_ready = 1'b0;
   logic signed [POS_W-1:0]               rsp_pos_ch0;
   logic signed [POS_W-1:0]               rsp_pos_ch1;
   logic signed [POS_W-1:0]               rsp_pos_ch2;
   logic signed [POS_W-1:0]               rsp_pos_ch3;
   logic signed [POS_W-1:0]               rsp_pos_ch4;
   logic                                  rsp_playing;
   logic        [SEG_W-1:0]               rsp_segment;
   logic                                  rsp_done_res;

   logic                                  csr_psel    = 1'b0;
   logic                                  csr_penable = 1'b0;
   logic                                  csr_pwrite  = 1'b0;
   logic        [krp_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic        [krp_pkg::CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic        [krp_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                                  csr_pready;

   // chance in percent that the sender idles / the receiver stalls a cycle
   int unsigned                           send_idle_pct = 0;
   int unsigned                           rsp_stall_pct = 0;
   int unsigned                           quiet_cycles  = 0;

   ramp_tracker_type                      board = new();

   keyframe_ramp_player #(
      .FRAMES   (FRAMES),
      .CHANNELS (CHANNELS)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_frame_sel   (req_frame_sel),
      .req_channel_sel (req_channel_sel),
      .req_key_value   (req_key_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pos_ch0     (rsp_pos_ch0),
      .rsp_pos_ch1     (rsp_pos_ch1),
      .rsp_pos_ch2     (rsp_pos_ch2),
      .rsp_pos_ch3     (rsp_pos_ch3),
      .rsp_pos_ch4     (rsp_pos_ch4),
      .rsp_playing     (rsp_playing),
      .rsp_segment     (rsp_segment),
      .rsp_done_res    (rsp_done_res),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Result side: check each accepted item, then pick the next ready value.
   // All inputs change by nonblocking assignment, so values read right after
   // the edge are still the ones the block saw at that edge.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            board.check_frame({rsp_pos_ch4, rsp_pos_ch3, rsp_pos_ch2, rsp_pos_ch1,
                               rsp_pos_ch0, rsp_playing, rsp_segment, rsp_done_res});
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Watchdog: give up once nothing moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------

   // Present one item and hold it until accepted. Valid stays high on return
   // so back-to-back items never drop it; the idle loop lowers it when needed.
   task automatic send_item(input logic [REQ_W-1:0] kind, input logic [FSEL_W-1:0] fsel,
                            input logic [CSEL_W-1:0] csel,
                            input logic signed [KEY_W-1:0] kv);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_type        <= kind;
      req_frame_sel   <= fsel;
      req_channel_sel <= csel;
      req_key_value   <= kv;
      req_valid       <= 1'b1;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      board.take_item(kind, fsel, csel, kv);
   endtask

   // tick and toggle with random don't-care fields
   task automatic send_plain(input logic [REQ_W-1:0] kind);
      send_item(kind, FSEL_W'($urandom_range(0, 7)), CSEL_W'($urandom_range(0, 7)),
                KEY_W'($urandom_range(0, 511)));
   endtask

   // keyframe write: mostly valid channels and angles, some out of range
   task automatic send_random_write();
      logic [CSEL_W-1:0] csel;
      logic [KEY_W-1:0]  kv;
      csel = ($urandom_range(99) < 85) ? CSEL_W'($urandom_range(0, CHANNELS - 1))
                                       : CSEL_W'($urandom_range(CHANNELS, 7));
      kv   = ($urandom_range(99) < 80) ? KEY_W'(int'($urandom_range(0, 360)) - 180)
                                       : KEY_W'($urandom_range(0, 511));
      send_item(krp_pkg::REQ_WRITE, FSEL_W'($urandom_range(0, 7)), csel, kv);
   endtask

   // Drop valid and hold until every expected result has come back
   task automatic settle_results();
      req_valid <= 1'b0;
      while (board.frames_due.size() != 0)
         @(posedge clock);
   endtask

   // APB write: setup cycle, then access; pready is always high
   task automatic csr_write(input logic idx, input int unsigned value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      board.set_register(idx, value);
   endtask

   // Reprogram both registers on an idle block
   task automatic apply_settings(input int unsigned step, input int unsigned last_idx);
      settle_results();
      csr_write(krp_pkg::REG_STEP_COUNT, step);
      csr_write(krp_pkg::REG_LAST_FRAME, last_idx);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
         IDLE_SEND: begin send_idle_pct = 51; rsp_stall_pct = 0;  end
         IDLE_RECV: begin send_idle_pct = 0;  rsp_stall_pct = 51; end
         default:   begin send_idle_pct = 37; rsp_stall_pct = 37; end
      endcase
   endtask

   // One phase: refresh part of the table, then play runs long enough to cross every
   // segment unless the tick count is capped, with a little noise sprinkled into the ticks.
   task automatic run_phase(input int unsigned step, input int unsigned last_idx,
                            input idle_mode_type mode);
      int          sent;
      int unsigned n_ticks;
      int unsigned pick;
      apply_settings(step, last_idx);
      set_idling(mode);
      sent = 0;
      repeat ($urandom_range(3, 8)) begin
         send_random_write();
         sent++;
      end
      while (sent < PHASE_ITEMS) begin
         // a toggle while playing stops; the next pass starts a fresh run
         send_plain(krp_pkg::REQ_TOGGLE);
         sent++;
         if (!board.running)
            continue;
         n_ticks = (step + 1) * last_idx + $urandom_range(0, 2);
         if (n_ticks > 60)
            n_ticks = $urandom_range(20, 60);
         for (int i = 0; i < n_ticks && sent < PHASE_ITEMS; i++) begin
            pick = $urandom_range(99);
            if (pick < 3)
               send_random_write();
            else if (pick < 5)
               send_plain(REQ_UNUSED);
            else if (pick < 6)
               send_plain(krp_pkg::REQ_TOGGLE);
            else
               send_plain(krp_pkg::REQ_TICK);
            sent++;
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   int unsigned phase_step [PHASES] = '{3, 1, 0, 4095, 2, 5, 1, 7, 4, 2, 6, 3000};
   int unsigned phase_last [PHASES] = '{7, 1, 3, 7, 4, 7, 7, 5, 2, 0, 6, 3};

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part, reset register values, no idling
      send_plain(krp_pkg::REQ_TICK);                         // tick while stopped
      send_plain(REQ_UNUSED);                                // unused code: no change
      send_item(krp_pkg::REQ_WRITE, 3'd0, 3'd0, 9'sd255);    // largest angle
      send_item(krp_pkg::REQ_WRITE, 3'd1, 3'd0, -9'sd256);   // smallest angle
      send_item(krp_pkg::REQ_WRITE, 3'd0, 3'd4, -9'sd180);
      send_item(krp_pkg::REQ_WRITE, 3'd1, 3'd4, 9'sd180);
      send_item(krp_pkg::REQ_WRITE, 3'd7, 3'd4, -9'sd1);     // all ones, last frame
      send_item(krp_pkg::REQ_WRITE, 3'd2, 3'd5, 9'sd100);    // channel out of range
      send_item(krp_pkg::REQ_WRITE, 3'd3, 3'd7, -9'sd5);     // channel out of range
      send_plain(krp_pkg::REQ_TOGGLE);                       // start: load frame 0
      repeat (3) send_plain(krp_pkg::REQ_TICK);
      send_plain(krp_pkg::REQ_TOGGLE);                       // stop mid-segment
      send_plain(krp_pkg::REQ_TOGGLE);                       // restart at segment 0
      send_plain(krp_pkg::REQ_TICK);
      send_plain(krp_pkg::REQ_TOGGLE);

      // zero step count and no segment to play
      apply_settings(0, 0);
      send_plain(krp_pkg::REQ_TOGGLE);                       // last frame 0: stays stopped
      send_plain(krp_pkg::REQ_TICK);
      apply_settings(0, 2);
      send_plain(krp_pkg::REQ_TOGGLE);
      repeat (3) send_plain(krp_pkg::REQ_TICK);              // advance, done, idle tick
      apply_settings(1, 1);
      send_plain(krp_pkg::REQ_TOGGLE);
      repeat (2) send_plain(krp_pkg::REQ_TICK);              // full-step ramp, then done

      // Random part: rotate through settings and idling patterns
      for (int p = 0; p < PHASES; p++)
         run_phase(phase_step[p], phase_last[p], idle_mode_type'(p % 4));

      settle_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (board.faults == 0 && board.frames_due.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
